[sv/nwa_pkg.sv]
// nwa_pkg: shared types and codes for the NFA word acceptor.
// Opcodes, configuration register indexes, FSM states, control bundle.
// No dependencies.
`timescale 1ns / 1ps

package nwa_pkg;

  localparam int STATE_W = 4;   // width of state index fields
  localparam int FINAL_W = 16;  // width of the final mask register
  localparam int SYM_W   = 8;   // width of the symbol field

  typedef logic [1:0] opcode_t;
  localparam opcode_t OP_ADD   = 2'd0;
  localparam opcode_t OP_SYM   = 2'd1;
  localparam opcode_t OP_QUERY = 2'd2;

  typedef logic cfg_idx_t;
  localparam cfg_idx_t CFG_START_STATE = 1'b0;
  localparam cfg_idx_t CFG_FINAL_MASK  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_SYM_RD,
    ST_SYM_CHAIN,
    ST_SYM_DONE,
    ST_QUERY
  } state_e;

  // broadcast from the sequencer to the cell row and the top datapath
  typedef struct packed {
    logic busy;
    logic clear;       // row clear sweep write
    logic rd_en;       // read row at current address
    logic add_wr;      // write back row with new transition bit
    logic load_start;  // active bit takes start bit
    logic chain;       // shift partial union along the row
    logic load_succ;   // active bit takes successor bit
    logic report;      // result beat next cycle
    logic query;       // result comes from the start set
  } ctrl_t;

endpackage

[sv/nwa_cell.sv]
// nwa_cell: one automaton state: its transition rows, active bit and a
// stage of the successor-union chain. Depends on nwa_pkg.
`timescale 1ns / 1ps

module nwa_cell #(
  parameter int NUM_STATES  = 16,
  parameter int SYMBOL_BITS = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  nwa_pkg::ctrl_t         ctrl_i,
  input  logic [SYMBOL_BITS-1:0] addr_i,
  input  logic                   sel_i,
  input  logic [NUM_STATES-1:0]  wr_mask_i,
  input  logic                   start_bit_i,
  input  logic                   succ_bit_i,
  input  logic [NUM_STATES-1:0]  part_i,
  output logic [NUM_STATES-1:0]  part_o
);

  localparam int ROWS = 1 << SYMBOL_BITS;

  logic [NUM_STATES-1:0] mem_q [ROWS];
  logic [NUM_STATES-1:0] rd_q;
  logic [NUM_STATES-1:0] part_q;
  logic                  act_q;
  logic                  we;
  logic [NUM_STATES-1:0] wdata;

  assign we    = ctrl_i.clear | (ctrl_i.add_wr & sel_i);
  assign wdata = ctrl_i.clear ? '0 : (rd_q | wr_mask_i);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[addr_i] <= wdata;
    end
    if (ctrl_i.rd_en) begin
      rd_q <= mem_q[addr_i];
    end
  end

  // partial union: everything upstream plus this state's row if active
  always_ff @(posedge clk_i) begin
    if (ctrl_i.chain) begin
      part_q <= part_i | ({NUM_STATES{act_q}} & rd_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
    end else if (ctrl_i.load_start) begin
      act_q <= start_bit_i;
    end else if (ctrl_i.load_succ) begin
      act_q <= succ_bit_i;
    end
  end

  assign part_o = part_q;

endmodule

[sv/nwa_ctrl.sv]
// nwa_ctrl: sequencer for the NFA word acceptor: clear sweep, transition
// read-modify-write, symbol chain timing, word tracking. Depends on nwa_pkg.
`timescale 1ns / 1ps

module nwa_ctrl #(
  parameter int NUM_STATES  = 16,
  parameter int SYMBOL_BITS = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  nwa_pkg::opcode_t       opcode_i,
  input  logic                   last_i,
  output nwa_pkg::ctrl_t         ctrl_o,
  output logic [SYMBOL_BITS-1:0] clr_addr_o
);

  localparam int CNT_W = $clog2(NUM_STATES);

  nwa_pkg::state_e        state_q, state_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [SYMBOL_BITS-1:0] clr_q, clr_d;
  logic                   inside_q, inside_d;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    clr_d    = clr_q;
    inside_d = inside_q;
    unique case (state_q)
      nwa_pkg::ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (&clr_q) begin
          state_d = nwa_pkg::ST_IDLE;
        end
      end
      nwa_pkg::ST_IDLE: begin
        if (start_i) begin
          unique case (opcode_i)
            nwa_pkg::OP_ADD:   state_d = nwa_pkg::ST_ADD_RD;
            nwa_pkg::OP_SYM:   state_d = nwa_pkg::ST_SYM_RD;
            nwa_pkg::OP_QUERY: state_d = nwa_pkg::ST_QUERY;
            default:           state_d = nwa_pkg::ST_IDLE;
          endcase
        end
      end
      nwa_pkg::ST_ADD_RD: state_d = nwa_pkg::ST_ADD_WR;
      nwa_pkg::ST_ADD_WR: state_d = nwa_pkg::ST_IDLE;
      nwa_pkg::ST_SYM_RD: begin
        cnt_d   = '0;
        state_d = nwa_pkg::ST_SYM_CHAIN;
      end
      nwa_pkg::ST_SYM_CHAIN: begin
        cnt_d = cnt_q + 1'b1;
        // last cell holds the full union once the chain has shifted through every cell
        if (cnt_q == CNT_W'(NUM_STATES - 1)) begin
          state_d = nwa_pkg::ST_SYM_DONE;
        end
      end
      nwa_pkg::ST_SYM_DONE: begin
        inside_d = !last_i;
        state_d  = nwa_pkg::ST_IDLE;
      end
      nwa_pkg::ST_QUERY: begin
        inside_d = 1'b0;
        state_d  = nwa_pkg::ST_IDLE;
      end
      default: state_d = nwa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o      = '0;
    ctrl_o.busy = (state_q != nwa_pkg::ST_IDLE);
    unique case (state_q)
      nwa_pkg::ST_CLEAR:     ctrl_o.clear = 1'b1;
      nwa_pkg::ST_IDLE:      ;
      nwa_pkg::ST_ADD_RD:    ctrl_o.rd_en = 1'b1;
      nwa_pkg::ST_ADD_WR:    ctrl_o.add_wr = 1'b1;
      nwa_pkg::ST_SYM_RD: begin
        ctrl_o.rd_en      = 1'b1;
        ctrl_o.load_start = !inside_q;
      end
      nwa_pkg::ST_SYM_CHAIN: ctrl_o.chain = 1'b1;
      nwa_pkg::ST_SYM_DONE: begin
        ctrl_o.load_succ = 1'b1;
        ctrl_o.report    = last_i;
      end
      nwa_pkg::ST_QUERY: begin
        ctrl_o.load_start = 1'b1;
        ctrl_o.report     = 1'b1;
        ctrl_o.query      = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= nwa_pkg::ST_CLEAR;
      cnt_q    <= '0;
      clr_q    <= '0;
      inside_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      clr_q    <= clr_d;
      inside_q <= inside_d;
    end
  end

  assign clr_addr_o = clr_q;

endmodule

[sv/nfa_word_acceptor_unit.sv]
// nfa_word_acceptor_unit: top level of the bit-parallel NFA word acceptor.
// Uses nwa_pkg, nwa_ctrl and a row of nwa_cell instances.
//
// channel   direction  handshake                       payload
// -------   ---------  ------------------------------  ------------------------
// item      in         start_i & !busy_o               opcode, from/to, symbol,
//                                                       last_symbol
// result    out        done_o, one cycle, no stall      accepted_o
// config    in         cfg_valid_i & cfg_ready_o        cfg_index_i, cfg_data_i
//
// After reset the transition rows are cleared by a sweep over all 2**SYMBOL_BITS
// row addresses (all cells in parallel); busy_o is high meanwhile.
// Add transition: busy after the beat for a row read, then a row write.
// Word symbol: busy for a row read, a chain pass (successor union moving one cell
// per cycle down the cell row) and a successor load; a word end then gives done_o.
// Empty-word query: busy in ST_QUERY, done_o in the cycle after. Opcode 3 is dropped.
// Results cannot be stalled; done_o is a one-cycle strobe.
// cfg_ready_o is low while busy_o is high, so registers only change between items.
`timescale 1ns / 1ps

module nfa_word_acceptor_unit #(
  parameter int NUM_STATES  = 16,
  parameter int SYMBOL_BITS = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  nwa_pkg::opcode_t                 opcode_i,
  input  logic [nwa_pkg::STATE_W-1:0]      from_state_i,
  input  logic [nwa_pkg::STATE_W-1:0]      to_state_i,
  input  logic [nwa_pkg::SYM_W-1:0]        symbol_i,
  input  logic                             last_symbol_i,
  output logic                             done_o,
  output logic                             accepted_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  nwa_pkg::cfg_idx_t                cfg_index_i,
  input  logic [nwa_pkg::FINAL_W-1:0]      cfg_data_i
);

  nwa_pkg::ctrl_t               ctrl;
  logic [SYMBOL_BITS-1:0]       clr_addr;
  logic [SYMBOL_BITS-1:0]       mem_addr;
  logic                         accept;

  logic [nwa_pkg::STATE_W-1:0]  start_state_q;
  logic [nwa_pkg::FINAL_W-1:0]  final_mask_q;

  logic [SYMBOL_BITS-1:0]       sym_q;
  logic                         last_q;
  logic [NUM_STATES-1:0]        sel_q, sel_d;
  logic [NUM_STATES-1:0]        to_mask_q, to_mask_d;
  logic                         to_ok;

  logic [NUM_STATES-1:0]        start_mask;
  logic [NUM_STATES-1:0]        final_ext;
  logic [NUM_STATES-1:0]        succ;
  logic [NUM_STATES-1:0]        part_chain [NUM_STATES+1];

  logic                         done_q;
  logic                         accepted_q;

  assign accept      = start_i && !ctrl.busy;
  assign busy_o      = ctrl.busy;
  assign cfg_ready_o = !ctrl.busy;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_state_q <= '0;
      final_mask_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        nwa_pkg::CFG_START_STATE: start_state_q <= cfg_data_i[nwa_pkg::STATE_W-1:0];
        nwa_pkg::CFG_FINAL_MASK:  final_mask_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // out-of-range states decode to no cell, so such a transition writes nothing
  assign to_ok = 32'(to_state_i) < NUM_STATES;

  for (genvar k = 0; k < NUM_STATES; k++) begin : g_dec
    assign sel_d[k]      = (32'(from_state_i) == k) && to_ok;
    assign to_mask_d[k]  = (32'(to_state_i) == k);
    assign start_mask[k] = (32'(start_state_q) == k);
    if (k < nwa_pkg::FINAL_W) begin : g_fin
      assign final_ext[k] = final_mask_q[k];
    end else begin : g_nofin
      assign final_ext[k] = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sym_q     <= symbol_i[SYMBOL_BITS-1:0];
      last_q    <= last_symbol_i;
      sel_q     <= sel_d;
      to_mask_q <= to_mask_d;
    end
  end

  nwa_ctrl #(
    .NUM_STATES  (NUM_STATES),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .opcode_i   (opcode_i),
    .last_i     (last_q),
    .ctrl_o     (ctrl),
    .clr_addr_o (clr_addr)
  );

  assign mem_addr      = ctrl.clear ? clr_addr : sym_q;
  assign part_chain[0] = '0;
  assign succ          = part_chain[NUM_STATES];

  for (genvar k = 0; k < NUM_STATES; k++) begin : g_cell
    nwa_cell #(
      .NUM_STATES  (NUM_STATES),
      .SYMBOL_BITS (SYMBOL_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .addr_i      (mem_addr),
      .sel_i       (sel_q[k]),
      .wr_mask_i   (to_mask_q),
      .start_bit_i (start_mask[k]),
      .succ_bit_i  (succ[k]),
      .part_i      (part_chain[k]),
      .part_o      (part_chain[k+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctrl.report;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.report) begin
      accepted_q <= ctrl.query ? |(start_mask & final_ext) : |(succ & final_ext);
    end
  end

  assign done_o     = done_q;
  assign accepted_o = accepted_q;

  // a real command always takes the block out of the idle state
  a_busy_after_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (opcode_i == nwa_pkg::OP_ADD || opcode_i == nwa_pkg::OP_SYM ||
                opcode_i == nwa_pkg::OP_QUERY)) |=> busy_o)
    else $error("command accepted but block went idle");

  // a result only follows a busy cycle
  a_done_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o))
    else $error("result strobe without preceding work");

  // successor set is taken only right after the chain has run
  a_succ_after_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.load_succ |-> $past(ctrl.chain))
    else $error("successor load without chain pass");

endmodule

[tb/sv/nfa_word_acceptor_unit_test.sv]
// nfa_word_acceptor_unit_test: self-checking regression for the NFA word acceptor.
// Drives items and register writes, predicts the verdict of every word, compares.
// Depends on nwa_pkg and nfa_word_acceptor_unit.
`timescale 1ns / 1ps

module nfa_word_acceptor_unit_test;

  localparam int               NUM_STATES  = 16;
  localparam int               SYMBOL_BITS = 8;
  localparam int               STALL_LIMIT = 2000;
  localparam int               SETTLE_CYC  = NUM_STATES + 4;
  localparam int               NUM_PHASES  = 12;
  localparam int               PHASE_ITEMS = 150;
  localparam nwa_pkg::opcode_t OP_UNUSED   = 2'd3;

  // verdict predictor plus queue of verdicts still owed by the block
  class verdict_scoreboard;
    bit [NUM_STATES-1:0]       succ_rows [NUM_STATES * (1 << SYMBOL_BITS)];
    bit [NUM_STATES-1:0]       active_states;
    bit                        in_word;
    bit [nwa_pkg::STATE_W-1:0] start_idx;
    bit [nwa_pkg::FINAL_W-1:0] accept_mask;
    bit                        pending_verdicts [$];
    int                        mismatches;

    function new();
      foreach (succ_rows[i]) succ_rows[i] = '0;
      active_states = '0;
      in_word       = 1'b0;
      start_idx     = '0;
      accept_mask   = '0;
      mismatches    = 0;
    endfunction

    function void write_reg(nwa_pkg::cfg_idx_t idx, bit [nwa_pkg::FINAL_W-1:0] data);
      if (idx == nwa_pkg::CFG_START_STATE) start_idx = data[nwa_pkg::STATE_W-1:0];
      else accept_mask = data;
    endfunction

    function bit [NUM_STATES-1:0] start_set();
      bit [NUM_STATES-1:0] s;
      s = '0;
      s[start_idx] = 1'b1;
      return s;
    endfunction

    function void owe_verdict(bit v);
      pending_verdicts = {pending_verdicts, v};
    endfunction

    function void note_item(nwa_pkg::opcode_t op, bit [nwa_pkg::STATE_W-1:0] from_q,
                            bit [nwa_pkg::STATE_W-1:0] to_q,
                            bit [nwa_pkg::SYM_W-1:0] sym, bit last);
      bit [NUM_STATES-1:0] next_set;
      next_set = '0;
      case (op)
        nwa_pkg::OP_ADD: begin
          succ_rows[{from_q, sym}][to_q] = 1'b1;
        end
        nwa_pkg::OP_SYM: begin
          if (!in_word) active_states = start_set();
          for (int q = 0; q < NUM_STATES; q++)
            if (active_states[q]) next_set |= succ_rows[{q[nwa_pkg::STATE_W-1:0], sym}];
          active_states = next_set;
          in_word = !last;
          if (last) owe_verdict(|(active_states & accept_mask));
        end
        nwa_pkg::OP_QUERY: begin
          in_word       = 1'b0;
          active_states = start_set();
          owe_verdict(|(active_states & accept_mask));
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic got);
      bit want;
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: unexpected result beat, accepted=%b", $time, got);
        return;
      end
      want = pending_verdicts.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: accepted mismatch, expected %b got %b", $time, want, got);
      end
    endfunction
  endclass

  logic                        clk_i;
  logic                        rst_ni;
  logic                        start_i;
  logic                        busy_o;
  nwa_pkg::opcode_t            opcode_i;
  logic [nwa_pkg::STATE_W-1:0] from_state_i;
  logic [nwa_pkg::STATE_W-1:0] to_state_i;
  logic [nwa_pkg::SYM_W-1:0]   symbol_i;
  logic                        last_symbol_i;
  logic                        done_o;
  logic                        accepted_o;
  logic                        cfg_valid_i;
  logic                        cfg_ready_o;
  nwa_pkg::cfg_idx_t           cfg_index_i;
  logic [nwa_pkg::FINAL_W-1:0] cfg_data_i;

  verdict_scoreboard sb = new();
  int                quiet_cycles = 0;

  nfa_word_acceptor_unit #(
    .NUM_STATES (NUM_STATES),
    .SYMBOL_BITS(SYMBOL_BITS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .opcode_i     (opcode_i),
    .from_state_i (from_state_i),
    .to_state_i   (to_state_i),
    .symbol_i     (symbol_i),
    .last_symbol_i(last_symbol_i),
    .done_o       (done_o),
    .accepted_o   (accepted_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (done_o === 1'b1) sb.check_result(accepted_o);
  end

  // watchdog: counts cycles with no beat on any channel
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("nfa_word_acceptor_unit regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(nwa_pkg::opcode_t op, bit [nwa_pkg::STATE_W-1:0] from_q,
                           bit [nwa_pkg::STATE_W-1:0] to_q,
                           bit [nwa_pkg::SYM_W-1:0] sym, bit last);
    @(negedge clk_i);
    start_i       = 1'b1;
    opcode_i      = op;
    from_state_i  = from_q;
    to_state_i    = to_q;
    symbol_i      = sym;
    last_symbol_i = last;
    forever begin
      @(posedge clk_i);
      if (busy_o === 1'b0) break;
    end
    sb.note_item(op, from_q, to_q, sym, last);
  endtask

  task automatic hold_off(int cycles);
    @(negedge clk_i);
    start_i = 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic sender_gap(int idle_pct);
    if ($urandom_range(0, 99) < idle_pct) hold_off($urandom_range(1, 4));
  endtask

  // wait for every owed verdict, then let a non-reporting item finish
  task automatic drain_verdicts(bit settle);
    @(negedge clk_i);
    start_i = 1'b0;
    while (sb.pending_verdicts.size() != 0) @(posedge clk_i);
    if (settle) repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_config(nwa_pkg::cfg_idx_t idx, bit [nwa_pkg::FINAL_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o === 1'b1) break;
    end
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  initial begin
    bit [nwa_pkg::STATE_W-1:0] phase_states [5];
    bit [nwa_pkg::SYM_W-1:0]   alphabet [3];
    bit [nwa_pkg::STATE_W-1:0] st_start;
    bit [nwa_pkg::FINAL_W-1:0] fin_mask;
    bit [nwa_pkg::STATE_W-1:0] f_q;
    bit [nwa_pkg::STATE_W-1:0] t_q;
    bit [nwa_pkg::SYM_W-1:0]   sym;
    int                        idle_pct;
    int                        issued;
    int                        pick;

    rst_ni        = 1'b0;
    start_i       = 1'b0;
    opcode_i      = nwa_pkg::OP_ADD;
    from_state_i  = '0;
    to_state_i    = '0;
    symbol_i      = '0;
    last_symbol_i = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = nwa_pkg::CFG_START_STATE;
    cfg_data_i    = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: states 1 and 15 accept, start in 0
    write_config(nwa_pkg::CFG_START_STATE, 16'hFFF0);
    write_config(nwa_pkg::CFG_FINAL_MASK, 16'h8002);
    send_item(nwa_pkg::OP_QUERY, 4'd0, 4'd0, 8'h00, 1'b0);
    send_item(nwa_pkg::OP_ADD, 4'd0, 4'd1, 8'h00, 1'b1);
    send_item(nwa_pkg::OP_ADD, 4'd1, 4'd15, 8'hFF, 1'b0);
    send_item(nwa_pkg::OP_ADD, 4'd15, 4'd0, 8'hAA, 1'b1);
    send_item(nwa_pkg::OP_SYM, 4'd15, 4'd15, 8'h00, 1'b1);
    send_item(nwa_pkg::OP_SYM, 4'd0, 4'd0, 8'h00, 1'b0);
    send_item(nwa_pkg::OP_SYM, 4'd7, 4'd9, 8'hFF, 1'b1);
    send_item(nwa_pkg::OP_SYM, 4'd0, 4'd0, 8'h55, 1'b1);
    // dead set stays dead, no early reject
    send_item(nwa_pkg::OP_SYM, 4'd0, 4'd0, 8'h55, 1'b0);
    send_item(nwa_pkg::OP_SYM, 4'd0, 4'd0, 8'h00, 1'b1);
    // query abandons a word in progress
    send_item(nwa_pkg::OP_SYM, 4'd0, 4'd0, 8'h00, 1'b0);
    send_item(nwa_pkg::OP_QUERY, 4'd15, 4'd15, 8'hFF, 1'b1);
    send_item(nwa_pkg::OP_SYM, 4'd0, 4'd0, 8'hFF, 1'b1);
    // transition added mid-word applies right away
    send_item(nwa_pkg::OP_SYM, 4'd0, 4'd0, 8'h00, 1'b0);
    send_item(nwa_pkg::OP_ADD, 4'd1, 4'd15, 8'h11, 1'b0);
    send_item(nwa_pkg::OP_SYM, 4'd0, 4'd0, 8'h11, 1'b1);
    send_item(OP_UNUSED, 4'd15, 4'd15, 8'hFF, 1'b1);
    // nondeterministic branch, union of successors
    send_item(nwa_pkg::OP_ADD, 4'd0, 4'd15, 8'h00, 1'b0);
    send_item(nwa_pkg::OP_SYM, 4'd0, 4'd0, 8'h00, 1'b0);
    send_item(nwa_pkg::OP_SYM, 4'd0, 4'd0, 8'hAA, 1'b1);
    send_item(nwa_pkg::OP_SYM, 4'd0, 4'd0, 8'h00, 1'b0);
    send_item(nwa_pkg::OP_SYM, 4'd0, 4'd0, 8'hFF, 1'b1);

    for (int p = 0; p < NUM_PHASES; p++) begin
      idle_pct = (p < 4) ? 16 : (p < 8) ? 78 : 0;
      case (p)
        0:       begin st_start = 4'd0;  fin_mask = 16'h0000; end
        1:       begin st_start = 4'd15; fin_mask = 16'hFFFF; end
        2:       begin st_start = 4'd15; fin_mask = 16'h8001; end
        default: begin
          st_start = 4'($urandom_range(0, 15));
          fin_mask = 16'($urandom_range(0, 65535));
        end
      endcase
      drain_verdicts(1'b1);
      write_config(nwa_pkg::CFG_START_STATE, {12'($urandom_range(0, 4095)), st_start});
      write_config(nwa_pkg::CFG_FINAL_MASK, fin_mask);

      // small automaton per phase so that words stay alive
      phase_states[0] = st_start;
      for (int k = 1; k < 5; k++) phase_states[k] = 4'($urandom_range(0, 15));
      foreach (alphabet[k]) alphabet[k] = 8'($urandom_range(0, 255));

      issued = 0;
      repeat (20) begin
        sender_gap(idle_pct);
        send_item(nwa_pkg::OP_ADD, phase_states[$urandom_range(0, 4)],
                  phase_states[$urandom_range(0, 4)],
                  alphabet[$urandom_range(0, 2)], 1'($urandom));
        issued++;
      end

      while (issued < PHASE_ITEMS) begin
        sender_gap(idle_pct);
        if ($urandom_range(0, 49) == 0) drain_verdicts(1'b0);
        pick = $urandom_range(0, 99);
        sym  = ($urandom_range(0, 9) < 9) ? alphabet[$urandom_range(0, 2)]
                                          : 8'($urandom_range(0, 255));
        f_q  = 4'($urandom_range(0, 15));
        t_q  = 4'($urandom_range(0, 15));
        if (pick < 12) begin
          if ($urandom_range(0, 9) < 7) begin
            f_q = phase_states[$urandom_range(0, 4)];
            t_q = phase_states[$urandom_range(0, 4)];
          end
          send_item(nwa_pkg::OP_ADD, f_q, t_q, sym, 1'($urandom));
          issued++;
        end else if (pick < 18) begin
          send_item(nwa_pkg::OP_QUERY, f_q, t_q, 8'($urandom_range(0, 255)), 1'($urandom));
          issued++;
        end else if (pick < 21) begin
          send_item(OP_UNUSED, f_q, t_q, 8'($urandom_range(0, 255)), 1'($urandom));
        end else begin
          send_item(nwa_pkg::OP_SYM, f_q, t_q, sym, $urandom_range(0, 3) == 0);
          issued++;
        end
      end
    end

    drain_verdicts(1'b1);
    if (sb.mismatches == 0 && sb.pending_verdicts.size() == 0) begin
      $display("nfa_word_acceptor_unit regression: pass");
    end else begin
      $display("nfa_word_acceptor_unit regression: fail");
    end
    $finish;
  end

endmodule

[sim.f]
sv/nwa_pkg.sv
sv/nwa_cell.sv
sv/nwa_ctrl.sv
sv/nfa_word_acceptor_unit.sv
tb/sv/nfa_word_acceptor_unit_test.sv
